### design/vgm_pkg.sv
// Package of the voxel greedy mesher: chunk geometry, voxel and normal codes,
// command codes, state encoding and the controller/datapath interface structs.
// Depends on nothing.
package vgm_pkg;

	localparam int CS     = 16;
	localparam int CW     = $clog2(CS + 1);
	localparam int VDEPTH = CS * CS * CS;
	localparam int MDEPTH = CS * CS;
	localparam int VAW    = $clog2(VDEPTH);
	localparam int MAW    = $clog2(MDEPTH);

	localparam logic [2:0] TYPE_AIR   = 3'd1;
	localparam logic [2:0] TYPE_STONE = 3'd2;
	localparam logic [2:0] TYPE_DIRT  = 3'd3;
	localparam logic [2:0] TYPE_GRASS = 3'd4;

	localparam logic [1:0] NORM_NONE = 2'd0;
	localparam logic [1:0] NORM_POS  = 2'd1;
	localparam logic [1:0] NORM_NEG  = 2'd2;

	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [7:0] TEX_GRASS_TOP  = 8'd0;
	localparam logic [7:0] TEX_GRASS_SIDE = 8'd1;
	localparam logic [7:0] TEX_DIRT       = 8'd2;
	localparam logic [7:0] TEX_STONE      = 8'd3;
	localparam logic [7:0] TEX_NONE       = 8'd255;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_FETCH = 2'd2
	} vgm_cmd_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_BUILD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_W_RD,
		ST_W_CHK,
		ST_H_RD,
		ST_H_CHK,
		ST_CLEAR,
		ST_EMIT,
		ST_DONE
	} vgm_state_t;

	typedef struct packed {
		logic clr_step;
		logic vox_wr;
		logic sweep_start;
		logic bld_init;
		logic bld_step;
		logic mask_set;
		logic scan_rd;
		logic scan_next;
		logic slice_adv;
		logic quad_init;
		logic w_rd;
		logic w_inc;
		logic h_init;
		logic h_rd;
		logic h_next;
		logic clr_init;
		logic clr_wr;
		logic emit_quad;
		logic emit_done;
	} vgm_ctl_t;

	typedef struct packed {
		logic init_last;
		logic active;
		logic mask_ready;
		logic bld_last;
		logic row_end;
		logic face;
		logic slice_last;
		logic axis_last;
		logic w_edge;
		logic match;
		logic h_edge;
		logic clr_done;
	} vgm_sts_t;

	function automatic logic [7:0] texture_of(logic [2:0] t, logic [1:0] axis, logic neg);
		logic [7:0] r;
		if (t == TYPE_GRASS)
			r = (axis == AXIS_Z && !neg) ? TEX_GRASS_TOP : TEX_GRASS_SIDE;
		else if (t == TYPE_DIRT)
			r = TEX_DIRT;
		else if (t == TYPE_STONE)
			r = TEX_STONE;
		else
			r = TEX_NONE;
		return r;
	endfunction

endpackage

### design/vgm_ctrl.sv
// Sequencer of the voxel greedy mesher: clearing pass, mask build, scan,
// rectangle growth and result emission. Depends on vgm_pkg.
module vgm_ctrl import vgm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  vgm_sts_t   sts,
	output vgm_ctl_t   ctl,
	output logic       busy
);

	vgm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_INIT: begin
				ctl.clr_step = 1'b1;
				if (sts.init_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_WRITE: ctl.vox_wr = 1'b1;
						CMD_START: ctl.sweep_start = 1'b1;
						CMD_FETCH: begin
							if (!sts.active)
								state_d = ST_DONE;
							else if (!sts.mask_ready) begin
								ctl.bld_init = 1'b1;
								state_d      = ST_BUILD;
							end else
								state_d = ST_SCAN_RD;
						end
						default: ;
					endcase
				end
			end
			ST_BUILD: begin
				ctl.bld_step = 1'b1;
				if (sts.bld_last) begin
					ctl.mask_set = 1'b1;
					state_d      = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (sts.row_end) begin
					ctl.slice_adv = 1'b1;
					if (sts.slice_last && sts.axis_last)
						state_d = ST_DONE;
					else begin
						ctl.bld_init = 1'b1;
						state_d      = ST_BUILD;
					end
				end else begin
					ctl.scan_rd = 1'b1;
					state_d     = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (sts.face) begin
					ctl.quad_init = 1'b1;
					state_d       = ST_W_RD;
				end else begin
					ctl.scan_next = 1'b1;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_W_RD: begin
				if (sts.w_edge) begin
					ctl.h_init = 1'b1;
					state_d    = ST_H_RD;
				end else begin
					ctl.w_rd = 1'b1;
					state_d  = ST_W_CHK;
				end
			end
			ST_W_CHK: begin
				if (sts.match) begin
					ctl.w_inc = 1'b1;
					state_d   = ST_W_RD;
				end else begin
					ctl.h_init = 1'b1;
					state_d    = ST_H_RD;
				end
			end
			ST_H_RD: begin
				if (sts.h_edge) begin
					ctl.clr_init = 1'b1;
					state_d      = ST_CLEAR;
				end else begin
					ctl.h_rd = 1'b1;
					state_d  = ST_H_CHK;
				end
			end
			ST_H_CHK: begin
				if (sts.match) begin
					ctl.h_next = 1'b1;
					state_d    = ST_H_RD;
				end else begin
					ctl.clr_init = 1'b1;
					state_d      = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				ctl.emit_quad = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_DONE: begin
				ctl.emit_done = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/vgm_dpath.sv
// Datapath of the voxel greedy mesher: voxel store, face mask memory, sweep
// counters, rectangle registers and result registers. Depends on vgm_pkg.
module vgm_dpath import vgm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  vgm_ctl_t   ctl,
	output vgm_sts_t   sts,
	input  logic [3:0] voxel_x,
	input  logic [3:0] voxel_y,
	input  logic [3:0] voxel_z,
	input  logic [2:0] voxel_type,
	output logic       result_valid,
	output logic       quad_valid,
	output logic       mesh_done,
	output logic [1:0] face_axis,
	output logic       normal_negative,
	output logic [2:0] face_type,
	output logic [7:0] texture_index,
	output logic [4:0] corner_x,
	output logic [4:0] corner_y,
	output logic [4:0] corner_z,
	output logic [4:0] quad_width,
	output logic [4:0] quad_height,
	output logic [15:0] vertex_base
);

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} xyz_t;

	// Places slice s and plane position (i, j) into chunk coordinates.
	function automatic xyz_t place(logic [1:0] axis, logic [CW-1:0] s,
			logic [CW-1:0] i, logic [CW-1:0] j);
		xyz_t c;
		case (axis)
			2'd0:    c = '{x: s, y: i, z: j};
			2'd1:    c = '{x: j, y: s, z: i};
			default: c = '{x: i, y: j, z: s};
		endcase
		return c;
	endfunction

	function automatic logic [VAW-1:0] vaddr(xyz_t c);
		return VAW'((int'(c.z) * CS + int'(c.y)) * CS + int'(c.x));
	endfunction

	function automatic logic [MAW-1:0] maddr(logic [CW-1:0] i, logic [CW-1:0] j);
		return MAW'(int'(j) * CS + int'(i));
	endfunction

	logic [2:0] vox_mem [VDEPTH];
	logic [4:0] mask_mem [MDEPTH];

	logic [1:0]    axis_q;
	logic [CW-1:0] sp_q, row_q, col_q, bi_q, bj_q;
	logic [CW-1:0] qi_q, qj_q, w_q, h_q, k_q, l_q;
	logic          active_q, mready_q;
	logic [15:0]   vcnt_q;
	logic [VAW-1:0] init_q;
	logic [4:0]    cur_q, mrd_q;

	logic          bv_s1, aoob_s1, boob_s1;
	logic [MAW-1:0] idx_s1;
	logic [2:0]    rda_s1, rdb_s1;

	xyz_t          ca, cb, cq;
	logic [CW-1:0] sa, qiw, qjh, qjl, qik, ncol;
	logic          wr_in_range;
	logic          vwe, mwe, mre;
	logic [VAW-1:0] vwaddr;
	logic [2:0]    vwdata;
	logic [MAW-1:0] mwaddr, mraddr;
	logic [4:0]    mwdata, bld_m;
	logic [2:0]    ta, tb;

	assign sa  = sp_q - CW'(1);
	assign ca  = place(axis_q, sa, bi_q, bj_q);
	assign cb  = place(axis_q, sp_q, bi_q, bj_q);
	assign cq  = place(axis_q, sp_q, qi_q, qj_q);
	assign qiw = qi_q + w_q;
	assign qjh = qj_q + h_q;
	assign qjl = qj_q + l_q;
	assign qik = qi_q + k_q;
	assign ncol = qiw;

	assign wr_in_range = (int'(voxel_x) < CS) && (int'(voxel_y) < CS) && (int'(voxel_z) < CS);

	// Voxel store: one write port, two registered read ports.
	always_comb begin
		vwe    = 1'b0;
		vwaddr = init_q;
		vwdata = TYPE_AIR;
		if (ctl.clr_step)
			vwe = 1'b1;
		else if (ctl.vox_wr && wr_in_range) begin
			vwe    = 1'b1;
			vwaddr = vaddr('{x: CW'(voxel_x), y: CW'(voxel_y), z: CW'(voxel_z)});
			vwdata = voxel_type;
		end
	end

	always_ff @(posedge clk) begin
		if (vwe)
			vox_mem[vwaddr] <= vwdata;
		if (ctl.bld_step) begin
			rda_s1 <= vox_mem[vaddr(ca)];
			rdb_s1 <= vox_mem[vaddr(cb)];
		end
	end

	// Face of one mask cell from the two neighbouring voxels.
	always_comb begin
		ta = aoob_s1 ? TYPE_AIR : rda_s1;
		tb = boob_s1 ? TYPE_AIR : rdb_s1;
		if (ta != TYPE_AIR && tb == TYPE_AIR)
			bld_m = {NORM_POS, ta};
		else if (tb != TYPE_AIR && ta == TYPE_AIR)
			bld_m = {NORM_NEG, tb};
		else
			bld_m = {NORM_NONE, 3'd0};
	end

	// Face mask: one write port, one registered read port.
	always_comb begin
		mwe    = bv_s1 | ctl.clr_wr;
		mwaddr = bv_s1 ? idx_s1 : maddr(qik, qjl);
		mwdata = bv_s1 ? bld_m : 5'd0;
		mre    = ctl.scan_rd | ctl.w_rd | ctl.h_rd;
		if (ctl.scan_rd)
			mraddr = maddr(col_q, row_q);
		else if (ctl.w_rd)
			mraddr = maddr(qiw, qj_q);
		else
			mraddr = maddr(qik, qjh);
	end

	always_ff @(posedge clk) begin
		if (mwe)
			mask_mem[mwaddr] <= mwdata;
		if (mre)
			mrd_q <= mask_mem[mraddr];
	end

	// Build pipeline stage bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bv_s1 <= 1'b0;
		else
			bv_s1 <= ctl.bld_step;
	end

	always_ff @(posedge clk) begin
		if (ctl.bld_step) begin
			aoob_s1 <= (sp_q == '0);
			boob_s1 <= (int'(sp_q) >= CS);
			idx_s1  <= maddr(bi_q, bj_q);
		end
	end

	// Sweep and scan control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= '0;
			sp_q     <= '0;
			row_q    <= '0;
			col_q    <= '0;
			active_q <= 1'b0;
			mready_q <= 1'b0;
			vcnt_q   <= '0;
			init_q   <= '0;
			bi_q     <= '0;
			bj_q     <= '0;
		end else begin
			if (ctl.clr_step)
				init_q <= init_q + VAW'(1);
			if (ctl.vox_wr) begin
				active_q <= 1'b0;
				mready_q <= 1'b0;
			end
			if (ctl.sweep_start) begin
				axis_q   <= '0;
				sp_q     <= '0;
				row_q    <= '0;
				col_q    <= '0;
				mready_q <= 1'b0;
				active_q <= 1'b1;
				vcnt_q   <= '0;
			end
			if (ctl.bld_init) begin
				bi_q <= '0;
				bj_q <= '0;
			end
			if (ctl.bld_step) begin
				if (int'(bi_q) == CS - 1) begin
					bi_q <= '0;
					bj_q <= bj_q + CW'(1);
				end else
					bi_q <= bi_q + CW'(1);
			end
			if (ctl.mask_set) begin
				mready_q <= 1'b1;
				row_q    <= '0;
				col_q    <= '0;
			end
			if (ctl.scan_next) begin
				if (int'(col_q) == CS - 1) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else
					col_q <= col_q + CW'(1);
			end
			if (ctl.slice_adv) begin
				mready_q <= 1'b0;
				if (int'(sp_q) == CS) begin
					sp_q <= '0;
					if (axis_q == AXIS_Z) begin
						axis_q   <= '0;
						active_q <= 1'b0;
					end else
						axis_q <= axis_q + 2'd1;
				end else
					sp_q <= sp_q + CW'(1);
			end
			if (ctl.emit_quad) begin
				vcnt_q <= vcnt_q + 16'd4;
				if (int'(ncol) >= CS) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else
					col_q <= ncol;
			end
		end
	end

	// Rectangle registers.
	always_ff @(posedge clk) begin
		if (ctl.quad_init) begin
			cur_q <= mrd_q;
			qi_q  <= col_q;
			qj_q  <= row_q;
			w_q   <= CW'(1);
		end
		if (ctl.w_inc)
			w_q <= w_q + CW'(1);
		if (ctl.h_init) begin
			h_q <= CW'(1);
			k_q <= '0;
		end
		if (ctl.h_next) begin
			if (k_q == w_q - CW'(1)) begin
				k_q <= '0;
				h_q <= h_q + CW'(1);
			end else
				k_q <= k_q + CW'(1);
		end
		if (ctl.clr_init) begin
			k_q <= '0;
			l_q <= '0;
		end
		if (ctl.clr_wr) begin
			if (k_q == w_q - CW'(1)) begin
				k_q <= '0;
				l_q <= l_q + CW'(1);
			end else
				k_q <= k_q + CW'(1);
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= ctl.emit_quad | ctl.emit_done;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_quad) begin
			quad_valid      <= 1'b1;
			mesh_done       <= 1'b0;
			face_axis       <= axis_q;
			normal_negative <= (cur_q[4:3] == NORM_NEG);
			face_type       <= cur_q[2:0];
			texture_index   <= texture_of(cur_q[2:0], axis_q, cur_q[4:3] == NORM_NEG);
			corner_x        <= 5'(cq.x);
			corner_y        <= 5'(cq.y);
			corner_z        <= 5'(cq.z);
			quad_width      <= 5'(w_q);
			quad_height     <= 5'(h_q);
			vertex_base     <= vcnt_q;
		end else if (ctl.emit_done) begin
			quad_valid      <= 1'b0;
			mesh_done       <= 1'b1;
			face_axis       <= '0;
			normal_negative <= 1'b0;
			face_type       <= '0;
			texture_index   <= '0;
			corner_x        <= '0;
			corner_y        <= '0;
			corner_z        <= '0;
			quad_width      <= '0;
			quad_height     <= '0;
			vertex_base     <= '0;
		end
	end

	assign sts.init_last  = (int'(init_q) == VDEPTH - 1);
	assign sts.active     = active_q;
	assign sts.mask_ready = mready_q;
	assign sts.bld_last   = (int'(bi_q) == CS - 1) && (int'(bj_q) == CS - 1);
	assign sts.row_end    = (int'(row_q) >= CS);
	assign sts.face       = (mrd_q[4:3] != NORM_NONE);
	assign sts.slice_last = (int'(sp_q) == CS);
	assign sts.axis_last  = (axis_q == AXIS_Z);
	assign sts.w_edge     = (int'(qiw) >= CS);
	assign sts.match      = (mrd_q == cur_q);
	assign sts.h_edge     = (int'(qjh) >= CS);
	assign sts.clr_done   = (l_q == h_q - CW'(1)) && (k_q == w_q - CW'(1));

endmodule

### design/voxel_greedy_mesher_core.sv
// Top level of the voxel greedy mesher: joins the sequencer and the datapath.
// Depends on vgm_pkg, vgm_ctrl and vgm_dpath.
//
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     cmd, voxel_x/y/z, voxel_type
// result    out        result_valid, one cycle  quad_valid ... vertex_base
//
// After reset the block clears the 4096-entry voxel store to air, one entry a
// cycle, and holds busy high until it is done.
// A write or a start command is carried out in the idle state. A fetch builds
// the face mask, after a set-up step, when a new slice begins (both voxels of a
// cell are read in the same cycle), then scans mask cells, tests cells while a
// rectangle grows and clears the cells that it covers; scan and growth share
// the single read port of the face mask.
// The result appears in the cycle after the fetch ends, for one cycle only;
// the receiver cannot stall it, and a new command may be taken in that cycle.
module voxel_greedy_mesher_core import vgm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  voxel_x,
	input  logic [3:0]  voxel_y,
	input  logic [3:0]  voxel_z,
	input  logic [2:0]  voxel_type,
	output logic        result_valid,
	output logic        quad_valid,
	output logic        mesh_done,
	output logic [1:0]  face_axis,
	output logic        normal_negative,
	output logic [2:0]  face_type,
	output logic [7:0]  texture_index,
	output logic [4:0]  corner_x,
	output logic [4:0]  corner_y,
	output logic [4:0]  corner_z,
	output logic [4:0]  quad_width,
	output logic [4:0]  quad_height,
	output logic [15:0] vertex_base
);

	// Commands from the sequencer and status back from the datapath.
	vgm_ctl_t ctl;
	vgm_sts_t sts;

	vgm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	vgm_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.voxel_x         (voxel_x),
		.voxel_y         (voxel_y),
		.voxel_z         (voxel_z),
		.voxel_type      (voxel_type),
		.result_valid    (result_valid),
		.quad_valid      (quad_valid),
		.mesh_done       (mesh_done),
		.face_axis       (face_axis),
		.normal_negative (normal_negative),
		.face_type       (face_type),
		.texture_index   (texture_index),
		.corner_x        (corner_x),
		.corner_y        (corner_y),
		.corner_z        (corner_z),
		.quad_width      (quad_width),
		.quad_height     (quad_height),
		.vertex_base     (vertex_base)
	);

`ifndef SYNTH
	// A result is either a quad or the end of the mesh, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (quad_valid != mesh_done))
		else $error("result is neither a single quad nor a done marker");

	// An accepted fetch always keeps the block busy in the next cycle.
	a_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_FETCH) |=> busy)
		else $error("fetch accepted without starting work");

	// A quad always covers at least one cell.
	a_quad_size: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && quad_valid) |-> (quad_width != 5'd0 && quad_height != 5'd0))
		else $error("quad with zero extent");
`endif

endmodule
